// ----- hdl/lhdc_pkg.sv -----
`timescale 1ns / 1ps

package lhdc_pkg;

  localparam int MAX_HITS  = 8192;
  localparam int IDX_W     = $clog2(MAX_HITS);
  localparam int LINK_W    = IDX_W + 1;
  localparam int CNT_W     = IDX_W + 1;
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 1;

  // link value with the top bit set means "no entry"
  localparam logic [LINK_W-1:0] NONE_LINK      = LINK_W'(MAX_HITS);
  localparam logic [CFG_W-1:0]  RESET_CAPACITY = CFG_W'(5000);

  localparam logic [CFG_IDX_W-1:0] REG_CACHE_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_HITS     = CFG_IDX_W'(1);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [LINK_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } link_port_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } flag_port_t;

  typedef struct packed {
    logic             out_of_range;
    logic             was_resident;
    logic             evicted;
    logic [IDX_W-1:0] evicted_index;
  } result_t;

endpackage

// ----- hdl/lru_hit_document_cache_unit.sv -----
`timescale 1ns / 1ps

// lru residency tracker for a hit-document cache
// input channel: in_valid/in_ready with in_hit_index; each item yields one result
// item on out_valid/out_ready: out_of_range, was_resident, evicted, evicted_index
// config port: cfg_we with cfg_index 0 = cache capacity, 1 = total hits; write only
// when the block is idle
// sequence: a valid hit steps through unlink, link1, link2, an optional evict step
// and done before loading the result register; an out-of-range item goes to done
// occupancy: a new item is taken only once the sequencer is back in idle; each
// link memory has one write and one read port for unlink, insert and eviction
// reset: head, tail and resident count clear at once, then a pass over all 8192
// entries clears the resident map one entry per cycle with in_ready held low
// stall: a finished result waits in the output register while the next item is
// accepted; that item then holds in its last step until the register is free

module lru_hit_document_cache_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lhdc_pkg::IDX_W-1:0]    in_hit_index,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_out_of_range,
  output logic                          out_was_resident,
  output logic                          out_evicted,
  output logic [lhdc_pkg::IDX_W-1:0]    out_evicted_index,
  input  logic                          cfg_we,
  input  logic [lhdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lhdc_pkg::CFG_W-1:0]    cfg_wdata
);

  import lhdc_pkg::*;

  // configuration registers
  logic [CFG_W-1:0] capacity_r, capacity_nxt;
  logic [CFG_W-1:0] total_hits_r, total_hits_nxt;

  // output register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic       seq_idle;
  logic       seq_done;
  logic       out_free;
  result_t    seq_result;
  link_port_t next_port;
  link_port_t prev_port;
  flag_port_t res_port;
  logic [LINK_W-1:0] next_rdata;
  logic [LINK_W-1:0] prev_rdata;
  logic              res_rdata;

  always_comb begin
    capacity_nxt   = capacity_r;
    total_hits_nxt = total_hits_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_CACHE_CAPACITY: capacity_nxt   = cfg_wdata;
        REG_TOTAL_HITS:     total_hits_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= RESET_CAPACITY;
      total_hits_r <= '0;
    end else begin
      capacity_r   <= capacity_nxt;
      total_hits_r <= total_hits_nxt;
    end
  end

  // result register frees up in the same cycle it is taken
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = seq_idle;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (seq_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_done) begin
      out_res_r <= seq_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_out_of_range  = out_res_r.out_of_range;
  assign out_was_resident  = out_res_r.was_resident;
  assign out_evicted       = out_res_r.evicted;
  assign out_evicted_index = out_res_r.evicted_index;

  // sequencer: unlink, insert at front, optional tail eviction
  lhdc_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (in_valid && in_ready),
    .start_idx      (in_hit_index),
    .cache_capacity (capacity_r),
    .total_hits     (total_hits_r),
    .out_free       (out_free),
    .idle           (seq_idle),
    .done           (seq_done),
    .result         (seq_result),
    .next_port      (next_port),
    .prev_port      (prev_port),
    .res_port       (res_port),
    .next_rdata     (next_rdata),
    .prev_rdata     (prev_rdata),
    .res_rdata      (res_rdata)
  );

  // forward links of the recency list
  lhdc_ram #(.DEPTH(MAX_HITS), .WIDTH(LINK_W)) u_next_mem (
    .clk   (clk),
    .we    (next_port.we),
    .waddr (next_port.waddr),
    .wdata (next_port.wdata),
    .re    (next_port.re),
    .raddr (next_port.raddr),
    .rdata (next_rdata)
  );

  // backward links of the recency list
  lhdc_ram #(.DEPTH(MAX_HITS), .WIDTH(LINK_W)) u_prev_mem (
    .clk   (clk),
    .we    (prev_port.we),
    .waddr (prev_port.waddr),
    .wdata (prev_port.wdata),
    .re    (prev_port.re),
    .raddr (prev_port.raddr),
    .rdata (prev_rdata)
  );

  // resident flags, cleared by the pass after reset
  lhdc_ram #(.DEPTH(MAX_HITS), .WIDTH(1)) u_res_mem (
    .clk   (clk),
    .we    (res_port.we),
    .waddr (res_port.waddr),
    .wdata (res_port.wdata),
    .re    (res_port.re),
    .raddr (res_port.raddr),
    .rdata (res_rdata)
  );

  // an out-of-range item touches nothing
  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_was_resident && !out_evicted)
    else $error("out-of-range item reported residency or eviction");

  // evicted index is zero without an eviction
  a_no_evict_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_index == '0)
    else $error("evicted index set without eviction");

  // the sequencer is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted two items back to back");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    seq_done |-> !out_valid_r || out_ready)
    else $error("result register overwritten while stalled");

endmodule

// ----- hdl/lhdc_ram.sv -----
`timescale 1ns / 1ps

module lhdc_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 14
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/lhdc_seq.sv -----
`timescale 1ns / 1ps

module lhdc_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lhdc_pkg::IDX_W-1:0] start_idx,
  input  logic [lhdc_pkg::CFG_W-1:0] cache_capacity,
  input  logic [lhdc_pkg::CFG_W-1:0] total_hits,
  input  logic                       out_free,
  output logic                       idle,
  output logic                       done,
  output lhdc_pkg::result_t          result,
  output lhdc_pkg::link_port_t       next_port,
  output lhdc_pkg::link_port_t       prev_port,
  output lhdc_pkg::flag_port_t       res_port,
  input  logic [lhdc_pkg::LINK_W-1:0] next_rdata,
  input  logic [lhdc_pkg::LINK_W-1:0] prev_rdata,
  input  logic                       res_rdata
);

  import lhdc_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_UNLINK = 7'b0000100,
    S_LINK1  = 7'b0001000,
    S_LINK2  = 7'b0010000,
    S_EVICT  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              oor_r, oor_nxt;
  logic              hit_r, hit_nxt;
  logic              evict_r, evict_nxt;
  logic [IDX_W-1:0]  victim_r, victim_nxt;
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LINK_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0] evict_pv;

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    idx_nxt     = idx_r;
    oor_nxt     = oor_r;
    hit_nxt     = hit_r;
    evict_nxt   = evict_r;
    victim_nxt  = victim_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    count_nxt   = count_r;
    idle        = 1'b0;
    done        = 1'b0;
    next_port   = '0;
    prev_port   = '0;
    res_port    = '0;
    // the tail is the current item only when it is the sole entry
    evict_pv    = (tail_r[IDX_W-1:0] == idx_r) ? NONE_LINK : prev_rdata;

    unique case (state_r)
      S_CLEAR: begin
        res_port.we    = 1'b1;
        res_port.waddr = clr_cnt_r;
        res_port.wdata = 1'b0;
        clr_cnt_nxt    = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        idle            = 1'b1;
        next_port.re    = 1'b1;
        next_port.raddr = start_idx;
        prev_port.re    = 1'b1;
        prev_port.raddr = start_idx;
        res_port.re     = 1'b1;
        res_port.raddr  = start_idx;
        if (start) begin
          idx_nxt   = start_idx;
          oor_nxt   = ({1'b0, start_idx} >= total_hits);
          hit_nxt   = 1'b0;
          evict_nxt = 1'b0;
          state_nxt = ({1'b0, start_idx} >= total_hits) ? S_DONE : S_UNLINK;
        end
      end
      S_UNLINK: begin
        hit_nxt = res_rdata;
        if (res_rdata) begin
          if (!next_rdata[IDX_W]) begin
            prev_port.we    = 1'b1;
            prev_port.waddr = next_rdata[IDX_W-1:0];
            prev_port.wdata = prev_rdata;
          end else begin
            tail_nxt = prev_rdata;
          end
          if (!prev_rdata[IDX_W]) begin
            next_port.we    = 1'b1;
            next_port.waddr = prev_rdata[IDX_W-1:0];
            next_port.wdata = next_rdata;
          end else begin
            head_nxt = next_rdata;
          end
          count_nxt = count_r - CNT_W'(1);
        end
        state_nxt = S_LINK1;
      end
      S_LINK1: begin
        next_port.we    = 1'b1;
        next_port.waddr = idx_r;
        next_port.wdata = head_r;
        if (!head_r[IDX_W]) begin
          prev_port.we    = 1'b1;
          prev_port.waddr = head_r[IDX_W-1:0];
          prev_port.wdata = {1'b0, idx_r};
        end else begin
          tail_nxt = {1'b0, idx_r};
        end
        state_nxt = S_LINK2;
      end
      S_LINK2: begin
        prev_port.we    = 1'b1;
        prev_port.waddr = idx_r;
        prev_port.wdata = NONE_LINK;
        prev_port.re    = 1'b1;
        prev_port.raddr = tail_r[IDX_W-1:0];
        res_port.we     = 1'b1;
        res_port.waddr  = idx_r;
        res_port.wdata  = 1'b1;
        head_nxt        = {1'b0, idx_r};
        count_nxt       = count_r + CNT_W'(1);
        // count after insert exceeds capacity
        state_nxt = (count_r >= cache_capacity) ? S_EVICT : S_DONE;
      end
      S_EVICT: begin
        tail_nxt = evict_pv;
        if (evict_pv[IDX_W]) begin
          head_nxt = NONE_LINK;
        end else begin
          next_port.we    = 1'b1;
          next_port.waddr = evict_pv[IDX_W-1:0];
          next_port.wdata = NONE_LINK;
        end
        res_port.we    = 1'b1;
        res_port.waddr = tail_r[IDX_W-1:0];
        res_port.wdata = 1'b0;
        count_nxt      = count_r - CNT_W'(1);
        evict_nxt      = 1'b1;
        victim_nxt     = tail_r[IDX_W-1:0];
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        done = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
      head_r    <= NONE_LINK;
      tail_r    <= NONE_LINK;
      count_r   <= '0;
      oor_r     <= 1'b0;
      hit_r     <= 1'b0;
      evict_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      oor_r     <= oor_nxt;
      hit_r     <= hit_nxt;
      evict_r   <= evict_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    victim_r <= victim_nxt;
  end

  assign result.out_of_range  = oor_r;
  assign result.was_resident  = hit_r;
  assign result.evicted       = evict_r;
  assign result.evicted_index = evict_r ? victim_r : '0;

endmodule
